// ===== hdl/dual_free_list_allocator_core_assert.svh =====
// ----------------------------------------------------------------------------
// dual free-list allocator assertion macros
// implication checks, same cycle and next cycle, empty under synthesis
// ----------------------------------------------------------------------------
`ifndef DUAL_FREE_LIST_ALLOCATOR_CORE_ASSERT_SVH
`define DUAL_FREE_LIST_ALLOCATOR_CORE_ASSERT_SVH

`ifndef SYNTHESIS
`define DFLA_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
`define DFLA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`else
`define DFLA_ASSERT_IMPL(label, clk, rst, ante, cons, msg)
`define DFLA_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif

`endif

// ===== hdl/dfla_pkg.sv =====
// ----------------------------------------------------------------------------
// dfla_pkg
// shared widths, codes and command/status types of the dual free-list allocator
// ----------------------------------------------------------------------------
package dfla_pkg;

  localparam int LIST_SLOTS_DEF  = 256;
  localparam int ENTRY_SLOTS_DEF = 4096;

  localparam int OPCODE_W = 3;
  localparam int INDEX_W  = 12;
  localparam int LINK_W   = 13;
  localparam int CHAIN_W  = 13;
  localparam int GRANT_W  = 13;
  localparam int STATUS_W = 2;
  localparam int LCNT_W   = 9;
  localparam int ECNT_W   = 13;
  localparam int LCFG_W   = 9;
  localparam int ECFG_W   = 13;
  localparam int SIZE_W   = (LCFG_W > ECFG_W) ? LCFG_W : ECFG_W;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = SIZE_W;

  localparam logic [LCFG_W-1:0] LIST_SIZE_RST  = LCFG_W'(256);
  localparam logic [ECFG_W-1:0] ENTRY_SIZE_RST = ECFG_W'(4096);

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_LIST_SIZE  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_ENTRY_SIZE = CFG_IDX_W'(1);

  // status codes
  localparam logic [STATUS_W-1:0] ST_OK    = STATUS_W'(0);
  localparam logic [STATUS_W-1:0] ST_EMPTY = STATUS_W'(1);
  localparam logic [STATUS_W-1:0] ST_RANGE = STATUS_W'(2);

  typedef enum logic [OPCODE_W-1:0] {
    OP_INIT        = 3'd0,
    OP_ALLOC_LIST  = 3'd1,
    OP_FREE_LIST   = 3'd2,
    OP_ALLOC_ENTRY = 3'd3,
    OP_FREE_ENTRY  = 3'd4,
    OP_FREE_CHAIN  = 3'd5,
    OP_LINK_WRITE  = 3'd6
  } op_t;

  typedef struct packed {
    logic accept;
    logic exec;
    logic init_run;
  } dfla_cmd_t;

  typedef struct packed {
    logic init_last;
  } dfla_stat_t;

endpackage

// ===== hdl/dfla_ctrl.sv =====
// ----------------------------------------------------------------------------
// dfla_ctrl
// request sequencer: a common execute state for every operation, a slot sweep for init
// ----------------------------------------------------------------------------
`include "dual_free_list_allocator_core_assert.svh"

module dfla_ctrl (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic [dfla_pkg::OPCODE_W-1:0]  opcode,
  input  dfla_pkg::dfla_stat_t           stat,
  output dfla_pkg::dfla_cmd_t            cmd,
  output logic                           busy,
  output logic                           done
);
  import dfla_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_INIT
  } state_t;

  state_t state;
  logic   accept;

  assign busy   = (state != S_IDLE);
  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            state <= (opcode == OP_INIT) ? S_INIT : S_EXEC;
          end
        end
        S_EXEC: begin
          state <= S_IDLE;
          done  <= 1'b1;
        end
        S_INIT: begin
          if (stat.init_last) begin
            state <= S_IDLE;
            done  <= 1'b1;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign cmd.accept   = accept;
  assign cmd.exec     = (state == S_EXEC);
  assign cmd.init_run = (state == S_INIT);

  `DFLA_ASSERT_NEXT(a_exec_single, clk, rst, state == S_EXEC, done && !busy, "exec too long")
  `DFLA_ASSERT_IMPL(a_done_idle, clk, rst, done, !busy, "result strobe while busy")
  `DFLA_ASSERT_NEXT(a_accept_busy, clk, rst, start && !busy, busy && !done, "request not started")

endmodule

// ===== hdl/dfla_datapath.sv =====
// ----------------------------------------------------------------------------
// dfla_datapath
// next-pointer memories, free heads, in-use counts and size registers
// ----------------------------------------------------------------------------
module dfla_datapath #(
  parameter int LIST_SLOTS  = dfla_pkg::LIST_SLOTS_DEF,
  parameter int ENTRY_SLOTS = dfla_pkg::ENTRY_SLOTS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  dfla_pkg::dfla_cmd_t                   cmd,
  output dfla_pkg::dfla_stat_t                  stat,
  input  logic                                  cfg_write,
  input  logic [dfla_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [dfla_pkg::CFG_DATA_W-1:0]       cfg_data,
  input  logic [dfla_pkg::OPCODE_W-1:0]         opcode,
  input  logic [dfla_pkg::INDEX_W-1:0]          item_index,
  input  logic signed [dfla_pkg::LINK_W-1:0]    link_value,
  input  logic [dfla_pkg::INDEX_W-1:0]          chain_first,
  input  logic [dfla_pkg::INDEX_W-1:0]          chain_last,
  input  logic [dfla_pkg::CHAIN_W-1:0]          chain_count,
  output logic signed [dfla_pkg::GRANT_W-1:0]   granted_index,
  output logic [dfla_pkg::STATUS_W-1:0]         status,
  output logic [dfla_pkg::LCNT_W-1:0]           lists_in_use,
  output logic [dfla_pkg::ECNT_W-1:0]           entries_in_use
);
  import dfla_pkg::*;

  localparam int LAW = $clog2(LIST_SLOTS);
  localparam int EAW = $clog2(ENTRY_SLOTS);
  localparam int LPW = LAW + 1;
  localparam int EPW = EAW + 1;

  // size registers
  logic [LCFG_W-1:0] list_size_cfg;
  logic [ECFG_W-1:0] entry_size_cfg;
  logic [LCFG_W-1:0] lsize;
  logic [ECFG_W-1:0] esize;
  logic [SIZE_W-1:0] lsize_x;
  logic [SIZE_W-1:0] esize_x;
  logic [SIZE_W-1:0] nmax;

  // latched request
  op_t                       req_op;
  logic [INDEX_W-1:0]        req_item;
  logic signed [LINK_W-1:0]  req_link;
  logic [INDEX_W-1:0]        req_first;
  logic [INDEX_W-1:0]        req_last;
  logic [CHAIN_W-1:0]        req_cnt;

  // pool state
  logic signed [LPW-1:0] list_head;
  logic signed [EPW-1:0] entry_head;
  logic [LCNT_W-1:0]     list_used;
  logic [ECNT_W-1:0]     entry_used;
  logic signed [LPW-1:0] list_head_next;
  logic signed [EPW-1:0] entry_head_next;
  logic [LCNT_W-1:0]     list_used_next;
  logic [ECNT_W-1:0]     entry_used_next;

  logic signed [LPW-1:0] list_mem [LIST_SLOTS];
  logic signed [EPW-1:0] entry_mem [ENTRY_SLOTS];
  logic signed [LPW-1:0] list_rdata;
  logic signed [EPW-1:0] entry_rdata;

  logic                  list_we;
  logic [LAW-1:0]        list_waddr;
  logic signed [LPW-1:0] list_wdata;
  logic                  entry_we;
  logic [EAW-1:0]        entry_waddr;
  logic signed [EPW-1:0] entry_wdata;

  logic [SIZE_W-1:0] init_idx;
  logic [SIZE_W-1:0] init_idx_inc;

  logic signed [GRANT_W-1:0] granted_c;
  logic [STATUS_W-1:0]       status_c;

  logic [SIZE_W-1:0] item_x;
  logic [SIZE_W-1:0] first_x;
  logic [SIZE_W-1:0] last_x;
  logic              link_bad;
  logic              list_head_ok;
  logic              entry_head_ok;

  // ---------------- configuration ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      list_size_cfg  <= LIST_SIZE_RST;
      entry_size_cfg <= ENTRY_SIZE_RST;
    end else if (cfg_write) begin
      if (cfg_index == REG_LIST_SIZE) begin
        list_size_cfg <= cfg_data[LCFG_W-1:0];
      end else if (cfg_index == REG_ENTRY_SIZE) begin
        entry_size_cfg <= cfg_data[ECFG_W-1:0];
      end
    end
  end

  // effective sizes, clamped to 1..slots
  always_comb begin
    priority if (list_size_cfg == '0) begin
      lsize = LCFG_W'(1);
    end else if (int'(list_size_cfg) > LIST_SLOTS) begin
      lsize = LCFG_W'(LIST_SLOTS);
    end else begin
      lsize = list_size_cfg;
    end
    priority if (entry_size_cfg == '0) begin
      esize = ECFG_W'(1);
    end else if (int'(entry_size_cfg) > ENTRY_SLOTS) begin
      esize = ECFG_W'(ENTRY_SLOTS);
    end else begin
      esize = entry_size_cfg;
    end
  end

  assign lsize_x = SIZE_W'(lsize);
  assign esize_x = SIZE_W'(esize);
  assign nmax    = (lsize_x > esize_x) ? lsize_x : esize_x;

  // ---------------- request latch ----------------
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      req_op    <= op_t'(opcode);
      req_item  <= item_index;
      req_link  <= link_value;
      req_first <= chain_first;
      req_last  <= chain_last;
      req_cnt   <= chain_count;
    end
  end

  // ---------------- init sweep counter ----------------
  assign init_idx_inc   = init_idx + SIZE_W'(1);
  assign stat.init_last = (init_idx_inc == nmax);

  always_ff @(posedge clk) begin
    if (rst) begin
      init_idx <= '0;
    end else if (cmd.accept) begin
      init_idx <= '0;
    end else if (cmd.init_run) begin
      init_idx <= init_idx_inc;
    end
  end

  // ---------------- operation logic ----------------
  assign item_x  = SIZE_W'(req_item);
  assign first_x = SIZE_W'(req_first);
  assign last_x  = SIZE_W'(req_last);

  // link must be none or a slot inside the entry pool
  assign link_bad = req_link[LINK_W-1] ? !(&req_link)
                                       : (SIZE_W'($unsigned(req_link)) >= esize_x);

  assign list_head_ok  = !list_head[LPW-1] && (int'(list_head[LAW-1:0]) < LIST_SLOTS);
  assign entry_head_ok = !entry_head[EPW-1] && (int'(entry_head[EAW-1:0]) < ENTRY_SLOTS);

  always_comb begin
    list_head_next  = list_head;
    entry_head_next = entry_head;
    list_used_next  = list_used;
    entry_used_next = entry_used;
    granted_c       = '1;
    status_c        = ST_OK;
    list_we         = 1'b0;
    list_waddr      = LAW'(req_item);
    list_wdata      = list_head;
    entry_we        = 1'b0;
    entry_waddr     = EAW'(req_item);
    entry_wdata     = entry_head;

    if (cmd.init_run) begin
      // chain slot i to i+1, the last one to none
      list_we     = (init_idx < lsize_x);
      list_waddr  = LAW'(init_idx);
      list_wdata  = (init_idx_inc == lsize_x) ? '1 : $signed(LPW'(init_idx_inc));
      entry_we    = (init_idx < esize_x);
      entry_waddr = EAW'(init_idx);
      entry_wdata = (init_idx_inc == esize_x) ? '1 : $signed(EPW'(init_idx_inc));
      if (stat.init_last) begin
        list_head_next  = '0;
        entry_head_next = '0;
        list_used_next  = '0;
        entry_used_next = '0;
      end
    end else if (cmd.exec) begin
      unique case (req_op)
        OP_ALLOC_LIST: begin
          if (list_head_ok) begin
            list_head_next = list_rdata;
            granted_c      = GRANT_W'(list_head);
            if (list_used != '1) begin
              list_used_next = list_used + LCNT_W'(1);
            end
          end else begin
            status_c = ST_EMPTY;
          end
        end
        OP_ALLOC_ENTRY: begin
          if (entry_head_ok) begin
            entry_head_next = entry_rdata;
            granted_c       = GRANT_W'(entry_head);
            if (entry_used != '1) begin
              entry_used_next = entry_used + ECNT_W'(1);
            end
          end else begin
            status_c = ST_EMPTY;
          end
        end
        OP_FREE_LIST: begin
          if (item_x >= lsize_x) begin
            status_c = ST_RANGE;
          end else begin
            list_we        = 1'b1;
            list_head_next = $signed(LPW'(req_item));
            if (list_used != '0) begin
              list_used_next = list_used - LCNT_W'(1);
            end
          end
        end
        OP_FREE_ENTRY: begin
          if (item_x >= esize_x) begin
            status_c = ST_RANGE;
          end else begin
            entry_we        = 1'b1;
            entry_head_next = $signed(EPW'(req_item));
            if (entry_used != '0) begin
              entry_used_next = entry_used - ECNT_W'(1);
            end
          end
        end
        OP_FREE_CHAIN: begin
          if (req_cnt == '0) begin
            status_c = ST_OK;
          end else if (first_x >= esize_x || last_x >= esize_x) begin
            status_c = ST_RANGE;
          end else begin
            // splice first..last in front of the free head
            entry_we        = 1'b1;
            entry_waddr     = EAW'(req_last);
            entry_head_next = $signed(EPW'(req_first));
            entry_used_next = (entry_used > ECNT_W'(req_cnt))
                              ? entry_used - ECNT_W'(req_cnt) : '0;
          end
        end
        OP_LINK_WRITE: begin
          if (item_x >= esize_x || link_bad) begin
            status_c = ST_RANGE;
          end else begin
            entry_we    = 1'b1;
            entry_wdata = EPW'(req_link);
          end
        end
        default: begin
          status_c = ST_OK;
        end
      endcase
    end
  end

  // ---------------- memories ----------------
  always_ff @(posedge clk) begin
    if (list_we) begin
      list_mem[list_waddr] <= list_wdata;
    end
    list_rdata <= list_mem[list_head[LAW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (entry_we) begin
      entry_mem[entry_waddr] <= entry_wdata;
    end
    entry_rdata <= entry_mem[entry_head[EAW-1:0]];
  end

  // ---------------- pool state and result ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      list_head  <= '0;
      entry_head <= '0;
      list_used  <= '0;
      entry_used <= '0;
    end else begin
      list_head  <= list_head_next;
      entry_head <= entry_head_next;
      list_used  <= list_used_next;
      entry_used <= entry_used_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec || (cmd.init_run && stat.init_last)) begin
      granted_index <= granted_c;
      status        <= status_c;
    end
  end

  // counts only move at the end of an operation, so they hold through the strobe
  assign lists_in_use   = list_used;
  assign entries_in_use = entry_used;

endmodule

// ===== hdl/dual_free_list_allocator_core.sv =====
// ----------------------------------------------------------------------------
// dual_free_list_allocator_core
// two linked free-list index pools (list heads and entries) with alloc, free,
// chain free, link write and init operations
// ----------------------------------------------------------------------------
// alloc, free, chain free, link write: the execute state covers the registered
//   read of the free head's next pointer, the result registers with the strobe;
//   a new request is taken in the strobe cycle, not while one is in flight
// init: a sweep over the slots, one slot of each pool per cycle
// done is a one-cycle strobe, the receiver cannot stall it
// reset: heads and counts zero, sizes 256 and 4096, memories undefined until init
module dual_free_list_allocator_core #(
  parameter int LIST_SLOTS  = dfla_pkg::LIST_SLOTS_DEF,
  parameter int ENTRY_SLOTS = dfla_pkg::ENTRY_SLOTS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_write,
  input  logic [dfla_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [dfla_pkg::CFG_DATA_W-1:0]       cfg_data,
  input  logic                                  start,
  output logic                                  busy,
  input  logic [dfla_pkg::OPCODE_W-1:0]         opcode,
  input  logic [dfla_pkg::INDEX_W-1:0]          item_index,
  input  logic signed [dfla_pkg::LINK_W-1:0]    link_value,
  input  logic [dfla_pkg::INDEX_W-1:0]          chain_first,
  input  logic [dfla_pkg::INDEX_W-1:0]          chain_last,
  input  logic [dfla_pkg::CHAIN_W-1:0]          chain_count,
  output logic                                  done,
  output logic signed [dfla_pkg::GRANT_W-1:0]   granted_index,
  output logic [dfla_pkg::STATUS_W-1:0]         status,
  output logic [dfla_pkg::LCNT_W-1:0]           lists_in_use,
  output logic [dfla_pkg::ECNT_W-1:0]           entries_in_use
);
  import dfla_pkg::*;

  dfla_cmd_t  cmd;
  dfla_stat_t stat;

  dfla_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .opcode (opcode),
    .stat   (stat),
    .cmd    (cmd),
    .busy   (busy),
    .done   (done)
  );

  dfla_datapath #(
    .LIST_SLOTS  (LIST_SLOTS),
    .ENTRY_SLOTS (ENTRY_SLOTS)
  ) u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .stat           (stat),
    .cfg_write      (cfg_write),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .opcode         (opcode),
    .item_index     (item_index),
    .link_value     (link_value),
    .chain_first    (chain_first),
    .chain_last     (chain_last),
    .chain_count    (chain_count),
    .granted_index  (granted_index),
    .status         (status),
    .lists_in_use   (lists_in_use),
    .entries_in_use (entries_in_use)
  );

endmodule
